[src/monotone_constraint_projection_unit_macros.svh]
// assertion macros for the monotone constraint projection unit
// clocked on clk_i and disabled while rst_ni is low; empty bodies under SYNTHESIS
`ifndef MONOTONE_CONSTRAINT_PROJECTION_UNIT_MACROS_SVH
`define MONOTONE_CONSTRAINT_PROJECTION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MCPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MCPU_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define MCPU_ASSERT(lbl, prop, msg)
`define MCPU_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[src/mcpu_pkg.sv]
// shared constants and controller/datapath interface types
// for the monotone constraint projection unit; no dependencies
package mcpu_pkg;

  localparam int unsigned VAL_W           = 32;
  localparam int unsigned LEN_W           = 7;
  localparam int unsigned DEFAULT_MAX_LEN = 64;
  localparam logic [LEN_W-1:0] LEN_RESET  = 7'd64;

  typedef enum logic [1:0] {
    OUT_ZERO = 2'd0,
    OUT_COPY = 2'd1,
    OUT_MEAN = 2'd2
  } out_sel_e;

  typedef struct packed {
    logic     load_wr;
    logic     load_last;
    logic     j_clr;
    logic     j_inc;
    logic     j_seg;
    logic     seg_set;
    logic     acc_add;
    logic     div_start;
    logic     out_load;
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic load_done;
    logic flag_cur;
    logic flag_nxt;
    logic j_first;
    logic j_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

[src/mcpu_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module mcpu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/mcpu_div.sv]
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// divisor is unsigned and nonzero; no dependencies
module mcpu_div #(
  parameter int unsigned DVD_W = 38,
  parameter int unsigned DVS_W = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [DVD_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DVD_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[DVD_W-1];
      quo_d  = dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
    end else if (busy_q) begin
      rem_d = fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

[src/mcpu_ctrl.sv]
// controller state machine: load, scan, segment sum, divide, emit
// depends on mcpu_pkg for the command and status structs
module mcpu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mcpu_pkg::sts_t sts_i,
  output mcpu_pkg::cmd_t cmd_o
);

  import mcpu_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_SCAN = 6'b000010,
    S_SUM  = 6'b000100,
    S_DIV  = 6'b001000,
    S_COPY = 6'b010000,
    S_MEAN = 6'b100000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    cmd.out_sel = OUT_ZERO;
    unique case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (sts_i.load_done) begin
            cmd.load_last = 1'b1;
            state_d       = S_SCAN;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (!sts_i.flag_cur && !sts_i.flag_nxt) begin
          // entry outside every run
          if (sts_i.out_free) begin
            cmd.out_load = 1'b1;
            if (sts_i.j_last) begin
              cmd.j_clr = 1'b1;
              state_d   = S_LOAD;
            end else begin
              cmd.j_inc = 1'b1;
            end
          end
        end else if (sts_i.j_first && sts_i.flag_cur) begin
          state_d = S_COPY;
        end else begin
          cmd.seg_set = 1'b1;
          state_d     = S_SUM;
        end
      end
      S_SUM: begin
        cmd.acc_add = 1'b1;
        if (!sts_i.flag_nxt) begin
          cmd.div_start = 1'b1;
          state_d       = S_DIV;
        end else if (sts_i.j_last) begin
          // run reaches the final flag: plain copy
          cmd.j_seg = 1'b1;
          state_d   = S_COPY;
        end else begin
          cmd.j_inc = 1'b1;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd.j_seg = 1'b1;
          state_d   = S_MEAN;
        end
      end
      S_COPY, S_MEAN: begin
        cmd.out_sel = (state_q == S_MEAN) ? OUT_MEAN : OUT_COPY;
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          if (sts_i.j_last) begin
            cmd.j_clr = 1'b1;
            state_d   = S_LOAD;
          end else begin
            cmd.j_inc = 1'b1;
            if (!sts_i.flag_nxt) begin
              state_d = S_SCAN;
            end
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_LOAD);
  assign cmd_o      = cmd;

endmodule

[src/mcpu_dp.sv]
// datapath: length register, entry and flag stores, index counters, sum, divider, output register
// depends on mcpu_pkg, mcpu_ram, mcpu_div and the assertion macro header
`include "monotone_constraint_projection_unit_macros.svh"

module mcpu_dp #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mcpu_pkg::LEN_W-1:0]            cfg_wdata_i,
  input  logic signed [mcpu_pkg::VAL_W-1:0]     entry_value_i,
  input  logic                                  constraint_active_i,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic signed [mcpu_pkg::VAL_W-1:0]     projected_value_o,
  output logic                                  last_entry_o,
  input  mcpu_pkg::cmd_t                        cmd_i,
  output mcpu_pkg::sts_t                        sts_o
);

  import mcpu_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned AW    = $clog2(MAX_LEN);
  localparam int unsigned SUM_W = VAL_W + $clog2(MAX_LEN);

  logic [LEN_W-1:0]        len_q;
  logic [CNT_W-1:0]        m_eff;
  logic [CNT_W-1:0]        load_cnt_q, load_cnt_d;
  logic                    flag_m_q, flag_m_d;
  logic [CNT_W-1:0]        j_q, j_d;
  logic [CNT_W-1:0]        j_nxt;
  logic [CNT_W-1:0]        j_d_nxt;
  logic [CNT_W-1:0]        seg_q, seg_d;
  logic [CNT_W-1:0]        seg_cnt;
  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic signed [SUM_W-1:0] acc_sum;
  logic [VAL_W:0]          rd_word;
  logic signed [VAL_W-1:0] rd_data;
  logic                    nxt_flag_rd;
  logic                    div_done;
  logic signed [SUM_W-1:0] quotient;
  logic signed [VAL_W-1:0] mean;
  logic signed [VAL_W:0]   diff;
  logic signed [VAL_W-1:0] diff_sat;
  logic signed [VAL_W-1:0] out_value_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0] out_value_q;
  logic                    out_last_q;
  logic                    out_free;
  sts_t                    sts;

  // effective length, clamped to 1..MAX_LEN
  always_comb begin
    if (len_q == '0) begin
      m_eff = CNT_W'(1);
    end else if (len_q > LEN_W'(MAX_LEN)) begin
      m_eff = CNT_W'(MAX_LEN);
    end else begin
      m_eff = len_q[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // loading; flags 0..m-1 go to the stores, the closing flag to its own register
  always_comb begin
    load_cnt_d = load_cnt_q;
    flag_m_d   = flag_m_q;
    if (cmd_i.load_wr) begin
      load_cnt_d = load_cnt_q + CNT_W'(1);
    end else if (cmd_i.load_last) begin
      flag_m_d   = constraint_active_i;
      load_cnt_d = '0;
    end
    if (cfg_we_i) begin
      load_cnt_d = '0;
    end
  end

  mcpu_ram #(
    .WIDTH (VAL_W + 1),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_wr),
    .waddr_i (load_cnt_q[AW-1:0]),
    .wdata_i ({constraint_active_i, entry_value_i}),
    .raddr_i (j_d[AW-1:0]),
    .rdata_o (rd_word)
  );

  // second copy of the flags, read one index ahead
  mcpu_ram #(
    .WIDTH (1),
    .DEPTH (MAX_LEN)
  ) u_flags (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_wr),
    .waddr_i (load_cnt_q[AW-1:0]),
    .wdata_i (constraint_active_i),
    .raddr_i (j_d_nxt[AW-1:0]),
    .rdata_o (nxt_flag_rd)
  );

  assign rd_data = rd_word[VAL_W-1:0];

  // read address follows the next index so rd_data always holds entry j_q
  assign j_nxt   = j_q + CNT_W'(1);
  assign j_d_nxt = j_d + CNT_W'(1);

  always_comb begin
    j_d = j_q;
    priority if (cmd_i.j_clr) begin
      j_d = '0;
    end else if (cmd_i.j_seg) begin
      j_d = seg_q;
    end else if (cmd_i.j_inc) begin
      j_d = j_nxt;
    end
  end

  assign seg_d   = cmd_i.seg_set ? j_q : seg_q;
  assign seg_cnt = j_q - seg_q + CNT_W'(1);

  assign acc_sum = acc_q + {{(SUM_W - VAL_W){rd_data[VAL_W-1]}}, rd_data};

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.seg_set) begin
      acc_d = '0;
    end else if (cmd_i.acc_add) begin
      acc_d = acc_sum;
    end
  end

  mcpu_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_sum),
    .divisor_i  (seg_cnt),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // mean of signed 32-bit entries always fits 32 bits
  assign mean = quotient[VAL_W-1:0];
  assign diff = {rd_data[VAL_W-1], rd_data} - {mean[VAL_W-1], mean};

  always_comb begin
    if (diff[VAL_W] != diff[VAL_W-1]) begin
      diff_sat = diff[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      diff_sat = diff[VAL_W-1:0];
    end
  end

  always_comb begin
    unique case (cmd_i.out_sel)
      OUT_ZERO: out_value_d = '0;
      OUT_COPY: out_value_d = rd_data;
      OUT_MEAN: out_value_d = diff_sat;
      default:  out_value_d = '0;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      flag_m_q    <= 1'b0;
      j_q         <= '0;
      seg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      load_cnt_q  <= load_cnt_d;
      flag_m_q    <= flag_m_d;
      j_q         <= j_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.out_load) begin
      out_value_q <= out_value_d;
      out_last_q  <= sts.j_last;
    end
  end

  always_comb begin
    sts.load_done = (load_cnt_q == m_eff);
    sts.flag_cur  = rd_word[VAL_W];
    sts.flag_nxt  = (j_nxt == m_eff) ? flag_m_q : nxt_flag_rd;
    sts.j_first   = (j_q == '0);
    sts.j_last    = (j_q == m_eff - CNT_W'(1));
    sts.div_done  = div_done;
    sts.out_free  = out_free;
  end

  assign sts_o             = sts;
  assign out_valid_o       = out_valid_q;
  assign projected_value_o = out_value_q;
  assign last_entry_o      = out_last_q;

  `MCPU_ASSERT_NEVER(a_out_overwrite, cmd_i.out_load && !out_free, "result register overwritten")
  `MCPU_ASSERT(a_load_idx_clear, cmd_i.load_wr |-> (j_q == '0), "scan index not cleared on load")
  `MCPU_ASSERT(a_seg_order, cmd_i.div_start |-> (j_q >= seg_q), "segment end before its start")
  `MCPU_ASSERT(a_last_reload, (cmd_i.out_load && sts.j_last) |=> (load_cnt_q == '0), "load count not zero after vector end")

endmodule

[src/monotone_constraint_projection_unit.sv]
// monotone constraint projection unit, top level; m+1 transactions per vector, one per cycle
// after the closing item input stalls until the last result is in the result register
// entries outside runs are emitted from the scan; each run adds a scan step, then a leading
//   run copies each entry, a trailing run sums and then copies each entry, an inner run
//   sums, divides and emits each entry minus the segment mean; output stalls delay results
// reset clears control state, length register resets to 64; stores hold no reset value
module monotone_constraint_projection_unit #(
  parameter int unsigned MAX_LEN = mcpu_pkg::DEFAULT_MAX_LEN
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mcpu_pkg::LEN_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [mcpu_pkg::VAL_W-1:0] entry_value_i,
  input  logic                              constraint_active_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mcpu_pkg::VAL_W-1:0] projected_value_o,
  output logic                              last_entry_o
);

  import mcpu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mcpu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mcpu_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .entry_value_i       (entry_value_i),
    .constraint_active_i (constraint_active_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .projected_value_o   (projected_value_o),
    .last_entry_o        (last_entry_o),
    .cmd_i               (cmd),
    .sts_o               (sts)
  );

endmodule

[dv/testbench.sv]
// self-checking testbench for monotone_constraint_projection_unit: directed and random
// vectors checked against a projection predictor; depends on mcpu_pkg and the unit RTL
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mcpu_pkg::*;

  localparam int MAX_LEN       = DEFAULT_MAX_LEN;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 200;
  localparam int IDLE_LIMIT    = 5000;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_LEN [NUM_PHASES] = '{1, 0, 2, 3, 5, 127, 8, 64};
  localparam int PHASE_VECS[NUM_PHASES] = '{12, 10, 15, 15, 4, 1, 5, 1};

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam longint SAT_HI = (longint'(1) <<< 31) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< 31);

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    active;
    int unsigned             gap;
  } entry_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } proj_t;

  logic                    clk_i               = 1'b0;
  logic                    rst_ni              = 1'b0;
  logic                    cfg_we_i            = 1'b0;
  logic [LEN_W-1:0]        cfg_wdata_i         = '0;
  logic                    in_valid_i          = 1'b0;
  logic                    in_stall_o;
  logic signed [VAL_W-1:0] entry_value_i       = '0;
  logic                    constraint_active_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i         = 1'b0;
  logic signed [VAL_W-1:0] projected_value_o;
  logic                    last_entry_o;

  monotone_constraint_projection_unit u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .entry_value_i       (entry_value_i),
    .constraint_active_i (constraint_active_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .projected_value_o   (projected_value_o),
    .last_entry_o        (last_entry_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // predictor state
  logic signed [VAL_W-1:0] stored_vals[MAX_LEN];
  logic                    active_bits[MAX_LEN+1];
  int                      fill_idx = 0;
  int                      cur_len  = MAX_LEN;

  entry_t      entry_pending_q[$];
  proj_t       projection_q[$];
  int unsigned entries_pushed = 0;
  int unsigned entries_taken  = 0;
  int unsigned mismatches     = 0;
  bit          send_burst     = 1'b0;
  bit          recv_burst     = 1'b0;

  // compute the projection of the loaded vector and queue one result per entry
  task automatic project_vector();
    logic signed [VAL_W-1:0] res[MAX_LEN];
    int     i, a, b, hi, k;
    longint sum, mean, diff;
    proj_t  r;
    for (k = 0; k < cur_len; k++) res[k] = '0;
    i = 0;
    while (i <= cur_len) begin
      if (!active_bits[i]) begin
        i++;
      end else begin
        a = i;
        b = i;
        while (b + 1 <= cur_len && active_bits[b+1]) b++;
        if (a == 0) begin
          hi = (b == cur_len) ? cur_len - 1 : b;
          for (k = 0; k <= hi; k++) res[k] = stored_vals[k];
        end else if (b == cur_len) begin
          for (k = a - 1; k < cur_len; k++) res[k] = stored_vals[k];
        end else begin
          sum = 0;
          for (k = a - 1; k <= b; k++) sum += longint'(stored_vals[k]);
          mean = sum / longint'(b - a + 2);
          for (k = a - 1; k <= b; k++) begin
            diff = longint'(stored_vals[k]) - mean;
            if (diff > SAT_HI) diff = SAT_HI;
            else if (diff < SAT_LO) diff = SAT_LO;
            res[k] = diff[VAL_W-1:0];
          end
        end
        i = b + 1;
      end
    end
    for (k = 0; k < cur_len; k++) begin
      r.value = res[k];
      r.last  = (k == cur_len - 1);
      projection_q.push_back(r);
    end
  endtask

  task automatic absorb_entry(input entry_t e);
    if (fill_idx < cur_len) begin
      stored_vals[fill_idx] = e.value;
      active_bits[fill_idx] = e.active;
      fill_idx++;
    end else begin
      active_bits[cur_len] = e.active;
      fill_idx = 0;
      project_vector();
    end
  endtask

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return VAL_W'($urandom_range(0, 4000)) - VAL_W'(2000);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_entry(input logic signed [VAL_W-1:0] value, input logic active);
    entry_t e;
    e.value  = value;
    e.active = active;
    e.gap    = send_burst ? 0 : $urandom_range(0, 8);
    entry_pending_q.push_back(e);
    entries_pushed++;
  endtask

  // four entries plus the closing flag item; flags[i] belongs to index i
  task automatic push_directed(input logic [4:0] flags, input logic signed [VAL_W-1:0] v0,
                               input logic signed [VAL_W-1:0] v1,
                               input logic signed [VAL_W-1:0] v2,
                               input logic signed [VAL_W-1:0] v3);
    push_entry(v0, flags[0]);
    push_entry(v1, flags[1]);
    push_entry(v2, flags[2]);
    push_entry(v3, flags[3]);
    push_entry(random_value(), flags[4]);
  endtask

  task automatic push_random_vector();
    int pct, k;
    case ($urandom_range(0, 5))
      0:       pct = 0;
      1:       pct = 100;
      2:       pct = 30;
      3:       pct = 80;
      default: pct = 50;
    endcase
    if ($urandom_range(0, 5) == 0) send_burst = !send_burst;
    for (k = 0; k <= cur_len; k++) push_entry(random_value(), $urandom_range(0, 99) < pct);
  endtask

  task automatic wait_for_idle();
    while (entries_taken != entries_pushed || projection_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    wait_for_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (len == 0) cur_len = 1;
    else if (len > MAX_LEN) cur_len = MAX_LEN;
    else cur_len = int'(len);
    // a write drops any partly loaded vector
    fill_idx = 0;
  endtask

  // driver
  entry_t      next_entry;
  entry_t      shown_entry;
  bit          next_ready = 1'b0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        absorb_entry(shown_entry);
        entries_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (!next_ready && entry_pending_q.size() != 0) begin
          next_entry = entry_pending_q.pop_front();
          next_ready = 1'b1;
          gap_left   = next_entry.gap;
        end
        if (next_ready && gap_left == 0) begin
          in_valid_i          <= 1'b1;
          entry_value_i       <= next_entry.value;
          constraint_active_i <= next_entry.active;
          shown_entry = next_entry;
          next_ready  = 1'b0;
        end else begin
          in_valid_i <= 1'b0;
          if (next_ready) gap_left--;
        end
      end
    end
  end

  // monitor and checker
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin : result_check
    proj_t exp_r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (projection_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, expected none, actual value %0d last %0b",
                   $time, projected_value_o, last_entry_o);
        end else begin
          exp_r = projection_q.pop_front();
          if (projected_value_o !== exp_r.value) begin
            mismatches++;
            $display("%0t: projected_value mismatch, expected %0d actual %0d",
                     $time, exp_r.value, projected_value_o);
          end
          if (last_entry_o !== exp_r.last) begin
            mismatches++;
            $display("%0t: last_entry mismatch, expected %0b actual %0b",
                     $time, exp_r.last, last_entry_o);
          end
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        hold_left = recv_burst ? 0 : $urandom_range(0, 8);
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left != 0);
    end
  end

  // watchdog on cycles without any transaction
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int p, v;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_length(LEN_W'(4));
    // whole range active, copies every entry
    push_directed(5'b11111, VAL_MAX, VAL_MIN, '0, -1);
    // inner run, mean over a saturating segment
    push_directed(5'b00110, VAL_MIN, VAL_MAX, VAL_MAX, 5);
    // run reaching the closing flag
    push_directed(5'b11000, 17, -3, VAL_MIN, VAL_MAX);
    // leading run, then a one-index inner run with negative mean truncation
    push_directed(5'b01011, 100, -200, -7, 4);
    // leading single, inner single and trailing single runs
    push_directed(5'b10101, -1, VAL_MAX, 9, VAL_MIN);

    for (p = 0; p < NUM_PHASES; p++) begin
      write_length(LEN_W'(PHASE_LEN[p]));
      for (v = 0; v < PHASE_VECS[p]; v++) push_random_vector();
      // partial vector, discarded by the next length write
      if (PHASE_LEN[p] == 3) begin
        push_entry(random_value(), 1'b1);
        push_entry(random_value(), 1'b0);
      end
    end

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && projection_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/mcpu_pkg.sv
src/mcpu_ram.sv
src/mcpu_div.sv
src/mcpu_ctrl.sv
src/mcpu_dp.sv
src/monotone_constraint_projection_unit.sv
dv/testbench.sv
